// ===== rtl/core/urtg_pkg.sv =====
// ----------------------------------------------------------------------------
// urtg_pkg: shared types and constants of the gated UART receiver
// Holds the item and configuration types that are passed between the front
// end, the back end and the top level, plus the register and kind codes.
// ----------------------------------------------------------------------------
package urtg_pkg;

	// Input kinds as they arrive on the slave tuser.
	localparam logic [1:0] KIND_TICK    = 2'd0;
	localparam logic [1:0] KIND_POP     = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] REG_HALF_BIT_TICKS    = 3'd0;
	localparam logic [2:0] REG_BIT_TICKS         = 3'd1;
	localparam logic [2:0] REG_FILTER_ENABLE     = 3'd2;
	localparam logic [2:0] REG_START_GATE_ENABLE = 3'd3;
	localparam logic [2:0] REG_START_GATE_BYTE   = 3'd4;
	localparam logic [2:0] REG_STOP_GATE_ENABLE  = 3'd5;
	localparam logic [2:0] REG_STOP_GATE_BYTE    = 3'd6;

	// Reset values of the bit timing registers.
	localparam logic [15:0] HALF_BIT_TICKS_RESET = 16'd3744;
	localparam logic [15:0] BIT_TICKS_RESET      = 16'd7488;

	// Bit position of the stop sample within a frame.
	localparam logic [3:0] STOP_POSITION = 4'd9;
	localparam logic [3:0] LAST_DATA_POSITION = 4'd8;

	localparam logic [15:0] TICK_COUNT_MAX = 16'hFFFF;

	// One classified item handed from the front end to the back end.
	typedef struct packed {
		logic tick;
		logic pop;
		logic restart;
		logic rx;
	} item_t;

	// Configuration register set.
	typedef struct packed {
		logic [15:0] half_bit_ticks;
		logic [15:0] bit_ticks;
		logic        filter_enable;
		logic        start_gate_enable;
		logic [7:0]  start_gate_byte;
		logic        stop_gate_enable;
		logic [7:0]  stop_gate_byte;
	} cfg_t;

endpackage

// ===== rtl/core/urtg_ram.sv =====
// ----------------------------------------------------------------------------
// urtg_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. The read data holds until
// the next read enable.
// ----------------------------------------------------------------------------
module urtg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/core/urtg_front.sv =====
// ----------------------------------------------------------------------------
// urtg_front: input acceptance, classification and decoupling queue
// Decodes the kind of each accepted item and parks it in a two-entry queue
// so that the input side never waits on the output side combinationally.
// ----------------------------------------------------------------------------
module urtg_front
	import urtg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  in_kind,
	input  logic        in_rx,
	output logic        q_valid,
	input  logic        q_ready,
	output item_t       q_item
);

	item_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	item_t      decoded;
	logic       push;
	logic       pull;

	always_comb begin
		decoded.tick    = (in_kind == KIND_TICK);
		decoded.pop     = (in_kind == KIND_POP);
		decoded.restart = (in_kind == KIND_RESTART);
		decoded.rx      = in_rx;
	end

	assign in_ready = (count_q != 2'd2);
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = entry_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pull     = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pull) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pull})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/urtg_back.sv =====
// ----------------------------------------------------------------------------
// urtg_back: receiver state, trigger gate, byte FIFO and result register
// Executes one classified item per cycle whenever the result register is
// free or being emptied, and keeps the result until it is taken.
// ----------------------------------------------------------------------------
module urtg_back
	import urtg_pkg::*;
#(
	parameter int FIFO_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        q_valid,
	output logic        q_ready,
	input  item_t       q_item,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  pop_data,
	output logic        pop_valid,
	output logic [6:0]  fill_count,
	output logic        gate_closed,
	output logic        framing_error,
	output logic        byte_received
);

	localparam int AW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(FIFO_DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(FIFO_DEPTH);

	logic          rx_prev_q, rx_prev_n;
	logic          frame_q, frame_n;
	logic [3:0]    pos_q, pos_n;
	logic [15:0]   cnt_q, cnt_n;
	logic [15:0]   cnt_inc;
	logic [15:0]   target;
	logic [7:0]    shift_q, shift_n;
	logic [2:0]    bit_idx;
	logic          err_q, err_n;
	logic          start_q, start_n;
	logic          stop_q, stop_n;
	logic [AW-1:0] head_q, head_n;
	logic [AW-1:0] tail_q, tail_n;
	logic [CW-1:0] count_q, count_n;
	logic          put;
	logic          exec;
	logic          wr_en;
	logic          rd_en;
	logic          recv;
	logic          pvalid;
	logic [7:0]    rd_data;

	logic          out_valid_q;
	logic          pvalid_q;
	logic [6:0]    fill_q;
	logic          gate_q;
	logic          ferr_q;
	logic          recv_q;

	assign q_ready = !out_valid_q || out_ready;
	assign exec    = q_valid && q_ready;
	assign target  = (pos_q == 4'd0) ? cfg.half_bit_ticks : cfg.bit_ticks;
	assign cnt_inc = (cnt_q != TICK_COUNT_MAX) ? cnt_q + 16'd1 : cnt_q;
	assign bit_idx = 3'(pos_q - 4'd1);

	always_comb begin
		rx_prev_n = rx_prev_q;
		frame_n   = frame_q;
		pos_n     = pos_q;
		cnt_n     = cnt_q;
		shift_n   = shift_q;
		err_n     = err_q;
		start_n   = start_q;
		stop_n    = stop_q;
		head_n    = head_q;
		tail_n    = tail_q;
		count_n   = count_q;
		put       = 1'b0;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		recv      = 1'b0;
		pvalid    = 1'b0;
		if (exec) begin
			if (q_item.tick) begin
				if (!frame_q) begin
					if (rx_prev_q && !q_item.rx) begin
						frame_n = 1'b1;
						pos_n   = 4'd0;
						cnt_n   = 16'd0;
						shift_n = 8'd0;
						err_n   = 1'b0;
					end
				end else if (cnt_inc >= target) begin
					cnt_n = 16'd0;
					if (pos_q >= 4'd1 && pos_q <= LAST_DATA_POSITION) begin
						if (q_item.rx) begin
							shift_n[bit_idx] = 1'b1;
						end
						pos_n = pos_q + 4'd1;
					end else if (pos_q == STOP_POSITION) begin
						if (q_item.rx) begin
							recv = 1'b1;
							if (!cfg.filter_enable) begin
								put = 1'b1;
							end else begin
								if (cfg.start_gate_enable) begin
									if (!start_q && shift_q == cfg.start_gate_byte) begin
										start_n = 1'b1;
									end
								end else begin
									start_n = 1'b1;
								end
								put = start_n && !stop_q;
								if (cfg.stop_gate_enable) begin
									if (!stop_q && shift_q == cfg.stop_gate_byte) begin
										stop_n = 1'b1;
									end
								end else begin
									stop_n = 1'b0;
								end
							end
							if (put && count_q != FULL_COUNT) begin
								wr_en   = 1'b1;
								tail_n  = (tail_q == LAST_ADDR) ? '0 : tail_q + AW'(1);
								count_n = count_q + CW'(1);
							end
						end else begin
							err_n = 1'b1;
						end
						frame_n = 1'b0;
						pos_n   = 4'd0;
					end else begin
						pos_n = 4'd1;
					end
				end else begin
					cnt_n = cnt_inc;
				end
				rx_prev_n = q_item.rx;
			end else if (q_item.pop) begin
				if (count_q != '0) begin
					rd_en   = 1'b1;
					pvalid  = 1'b1;
					head_n  = (head_q == LAST_ADDR) ? '0 : head_q + AW'(1);
					count_n = count_q - CW'(1);
				end
			end else if (q_item.restart) begin
				head_n  = '0;
				tail_n  = '0;
				count_n = '0;
				frame_n = 1'b0;
				pos_n   = 4'd0;
				cnt_n   = 16'd0;
				shift_n = 8'd0;
				err_n   = 1'b0;
				start_n = 1'b0;
				stop_n  = 1'b0;
			end
		end
	end

	urtg_ram #(
		.WIDTH(8),
		.DEPTH(FIFO_DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(tail_q),
		.wr_data(shift_q),
		.rd_en  (rd_en),
		.rd_addr(head_q),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_prev_q   <= 1'b1;
			frame_q     <= 1'b0;
			pos_q       <= 4'd0;
			cnt_q       <= 16'd0;
			shift_q     <= 8'd0;
			err_q       <= 1'b0;
			start_q     <= 1'b0;
			stop_q      <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rx_prev_q <= rx_prev_n;
			frame_q   <= frame_n;
			pos_q     <= pos_n;
			cnt_q     <= cnt_n;
			shift_q   <= shift_n;
			err_q     <= err_n;
			start_q   <= start_n;
			stop_q    <= stop_n;
			head_q    <= head_n;
			tail_q    <= tail_n;
			count_q   <= count_n;
			if (exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload; the popped byte itself sits in the RAM read register.
	always_ff @(posedge clk) begin
		if (exec) begin
			pvalid_q <= pvalid;
			fill_q   <= 7'(count_n);
			gate_q   <= stop_n;
			ferr_q   <= err_n;
			recv_q   <= recv;
		end
	end

	assign out_valid     = out_valid_q;
	assign pop_data      = pvalid_q ? rd_data : 8'd0;
	assign pop_valid     = pvalid_q;
	assign fill_count    = fill_q;
	assign gate_closed   = gate_q;
	assign framing_error = ferr_q;
	assign byte_received = recv_q;

endmodule

// ===== rtl/core/uart_rx_trigger_gated_fifo_top.sv =====
// ----------------------------------------------------------------------------
// uart_rx_trigger_gated_fifo_top: tick-driven 8N1 receiver with trigger gate
// Each input transfer is one line tick, a FIFO pop or a restart; each one
// yields exactly one status transfer on the master side.
// ----------------------------------------------------------------------------
// Each result passes through the front-end queue and the back-end result
// register before it is presented on the master side.
// Throughput: one transfer per cycle while results are taken; the back end
// updates receiver and FIFO state together; the RAM has a read and a write port.
// Reset: arst_n clears the receiver, trigger, FIFO pointers and configuration
// to their defaults at once; the FIFO storage itself is not cleared.
// ----------------------------------------------------------------------------
module uart_rx_trigger_gated_fifo_top
	import urtg_pkg::*;
#(
	parameter int FIFO_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// Slave side: one tick, pop or restart per transfer.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] rx_level, [7:1] zero
	input  logic [1:0]  s_tuser,   // [1:0] kind
	// Master side: one status result per transfer.
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] pop_data, [8] pop_valid, [15:9] fill_count, [16] gate_closed,
	// [17] framing_error, [18] byte_received, [23:19] zero
	output logic [23:0] m_tdata,
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t       cfg_q;
	logic       q_valid;
	logic       q_ready;
	item_t      q_item;
	logic [7:0] pop_data;
	logic       pop_valid;
	logic [6:0] fill_count;
	logic       gate_closed;
	logic       framing_error;
	logic       byte_received;

	// Configuration registers are written directly; the channel never stalls.
	// Writes to an index beyond the register list are accepted and ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_bit_ticks    <= HALF_BIT_TICKS_RESET;
			cfg_q.bit_ticks         <= BIT_TICKS_RESET;
			cfg_q.filter_enable     <= 1'b0;
			cfg_q.start_gate_enable <= 1'b0;
			cfg_q.start_gate_byte   <= 8'd0;
			cfg_q.stop_gate_enable  <= 1'b0;
			cfg_q.stop_gate_byte    <= 8'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HALF_BIT_TICKS:    cfg_q.half_bit_ticks    <= cfg_data;
				REG_BIT_TICKS:         cfg_q.bit_ticks         <= cfg_data;
				REG_FILTER_ENABLE:     cfg_q.filter_enable     <= cfg_data[0];
				REG_START_GATE_ENABLE: cfg_q.start_gate_enable <= cfg_data[0];
				REG_START_GATE_BYTE:   cfg_q.start_gate_byte   <= cfg_data[7:0];
				REG_STOP_GATE_ENABLE:  cfg_q.stop_gate_enable  <= cfg_data[0];
				REG_STOP_GATE_BYTE:    cfg_q.stop_gate_byte    <= cfg_data[7:0];
				default:               cfg_q <= cfg_q;
			endcase
		end
	end

	// The front end decodes the kind and buffers up to two items, so the
	// slave side is not stalled by a waiting result until the queue is full.
	urtg_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_kind (s_tuser),
		.in_rx   (s_tdata[0]),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_item  (q_item)
	);

	// The back end runs the bit timing, the trigger gate and the byte FIFO,
	// and holds each result in its output register until it is taken.
	urtg_back #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.q_ready      (q_ready),
		.q_item       (q_item),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.pop_data     (pop_data),
		.pop_valid    (pop_valid),
		.fill_count   (fill_count),
		.gate_closed  (gate_closed),
		.framing_error(framing_error),
		.byte_received(byte_received)
	);

	assign m_tdata = {5'd0, byte_received, framing_error, gate_closed,
		fill_count, pop_valid, pop_data};

	// A result never reports both a pop and a completed frame.
	a_pop_xor_recv: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(pop_valid && byte_received))
		else $error("pop and frame completion reported in one result");

	// A frame completed with a high stop bit cannot leave the error flag set.
	a_recv_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && byte_received |-> !framing_error)
		else $error("framing error flagged on a good frame");

	// An item waiting for the back end stays queued until it is taken.
	a_queue_holds: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && !q_ready |=> q_valid)
		else $error("queued item lost while back end stalled");

	// A status word that is not taken stays valid and unchanged.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("status word changed while waiting on the master side");

endmodule

// ===== verif/urtg_status_sb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// urtg_status_sb_pkg: status prediction and checking for the gated receiver
// Keeps a cycle-free model of the receiver, trigger gate and byte FIFO,
// turns every accepted slave transfer into the status word it must produce
// and compares the master-side status transfers against that list in order.
// ----------------------------------------------------------------------------
package urtg_status_sb_pkg;
	import urtg_pkg::*;

	// The fourth kind code has no function in the block and only reports status.
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int FIFO_SLOTS = 64;

	typedef struct packed {
		logic       byte_received;
		logic       framing_error;
		logic       gate_closed;
		logic [6:0] fill_count;
		logic       pop_valid;
		logic [7:0] pop_data;
	} status_t;

	class uart_status_scoreboard;
		cfg_t        regs;
		logic        line_prev;
		logic        in_frame;
		logic [3:0]  sample_index;
		logic [15:0] tick_count;
		logic [7:0]  rx_shift;
		logic        frame_error;
		logic        start_open;
		logic        stop_closed;
		logic [7:0]  fifo_mem [FIFO_SLOTS];
		int unsigned rd_ptr;
		int unsigned wr_ptr;
		int unsigned fifo_fill;
		status_t     pending_status [$];
		int unsigned mismatches;
		int unsigned good_frames;
		int unsigned bad_frames;
		int unsigned pops_hit;
		int unsigned drops;
		int unsigned gate_closures;

		function new();
			regs = '0;
			regs.half_bit_ticks = HALF_BIT_TICKS_RESET;
			regs.bit_ticks = BIT_TICKS_RESET;
			line_prev = 1'b1;
			in_frame = 1'b0;
			sample_index = '0;
			tick_count = '0;
			rx_shift = '0;
			frame_error = 1'b0;
			start_open = 1'b0;
			stop_closed = 1'b0;
			rd_ptr = 0;
			wr_ptr = 0;
			fifo_fill = 0;
			mismatches = 0;
			good_frames = 0;
			bad_frames = 0;
			pops_hit = 0;
			drops = 0;
			gate_closures = 0;
		endfunction

		function void write_register(logic [2:0] index, logic [15:0] data);
			case (index)
				REG_HALF_BIT_TICKS:    regs.half_bit_ticks = data;
				REG_BIT_TICKS:         regs.bit_ticks = data;
				REG_FILTER_ENABLE:     regs.filter_enable = data[0];
				REG_START_GATE_ENABLE: regs.start_gate_enable = data[0];
				REG_START_GATE_BYTE:   regs.start_gate_byte = data[7:0];
				REG_STOP_GATE_ENABLE:  regs.stop_gate_enable = data[0];
				REG_STOP_GATE_BYTE:    regs.stop_gate_byte = data[7:0];
				default: ;
			endcase
		endfunction

		// A byte that finds the FIFO full is lost.
		function void queue_byte(logic [7:0] value);
			if (fifo_fill < FIFO_SLOTS) begin
				fifo_mem[wr_ptr] = value;
				wr_ptr = (wr_ptr + 1) % FIFO_SLOTS;
				fifo_fill++;
			end else begin
				drops++;
			end
		endfunction

		function void pass_gate(logic [7:0] value);
			if (!regs.filter_enable) begin
				queue_byte(value);
				return;
			end
			if (regs.start_gate_enable) begin
				if (!start_open && value == regs.start_gate_byte)
					start_open = 1'b1;
			end else begin
				start_open = 1'b1;
			end
			if (start_open && !stop_closed)
				queue_byte(value);
			// The closing byte itself is still queued above.
			if (regs.stop_gate_enable) begin
				if (!stop_closed && value == regs.stop_gate_byte) begin
					stop_closed = 1'b1;
					gate_closures++;
				end
			end else begin
				stop_closed = 1'b0;
			end
		endfunction

		// One line tick; returns 1 when a frame ends with a high stop sample.
		function logic sample_line(logic rx);
			logic        done;
			logic [15:0] target;
			done = 1'b0;
			if (!in_frame) begin
				if (line_prev && !rx) begin
					in_frame = 1'b1;
					sample_index = '0;
					tick_count = '0;
					rx_shift = '0;
					frame_error = 1'b0;
				end
			end else begin
				target = (sample_index == 4'd0) ? regs.half_bit_ticks : regs.bit_ticks;
				if (tick_count < TICK_COUNT_MAX)
					tick_count++;
				// Compared after the increment, so a count of zero behaves as one.
				if (tick_count >= target) begin
					tick_count = '0;
					if (sample_index >= 4'd1 && sample_index <= LAST_DATA_POSITION) begin
						if (rx)
							rx_shift[sample_index - 4'd1] = 1'b1;
						sample_index++;
					end else if (sample_index == STOP_POSITION) begin
						if (rx) begin
							pass_gate(rx_shift);
							done = 1'b1;
							good_frames++;
						end else begin
							frame_error = 1'b1;
							bad_frames++;
						end
						in_frame = 1'b0;
						sample_index = '0;
					end else begin
						sample_index = 4'd1;
					end
				end
			end
			line_prev = rx;
			return done;
		endfunction

		function void note_transfer(logic [1:0] kind, logic rx);
			status_t result;
			result = '0;
			case (kind)
				KIND_TICK: result.byte_received = sample_line(rx);
				KIND_POP: begin
					if (fifo_fill > 0) begin
						result.pop_data = fifo_mem[rd_ptr];
						result.pop_valid = 1'b1;
						rd_ptr = (rd_ptr + 1) % FIFO_SLOTS;
						fifo_fill--;
						pops_hit++;
					end
				end
				KIND_RESTART: begin
					// The line history survives a restart.
					rd_ptr = 0;
					wr_ptr = 0;
					fifo_fill = 0;
					in_frame = 1'b0;
					sample_index = '0;
					tick_count = '0;
					rx_shift = '0;
					frame_error = 1'b0;
					start_open = 1'b0;
					stop_closed = 1'b0;
				end
				default: ;
			endcase
			result.fill_count = 7'(fifo_fill);
			result.gate_closed = stop_closed;
			result.framing_error = frame_error;
			pending_status.push_back(result);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_status(logic [23:0] word);
			status_t want;
			if (pending_status.size() == 0) begin
				$error("status transfer %h arrived with nothing pending", word);
				mismatches++;
				return;
			end
			want = pending_status.pop_front();
			compare_field("pop_data", want.pop_data, word[7:0]);
			compare_field("pop_valid", want.pop_valid, word[8]);
			compare_field("fill_count", want.fill_count, word[15:9]);
			compare_field("gate_closed", want.gate_closed, word[16]);
			compare_field("framing_error", want.framing_error, word[17]);
			compare_field("byte_received", want.byte_received, word[18]);
		endfunction
	endclass

endpackage

// ===== verif/tb_uart_rx_trigger_gated_fifo_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uart_rx_trigger_gated_fifo_top: self-checking bench for the gated receiver
// Drives serial frames one tick per transfer, interleaved with pops, restarts
// and line noise, across many timing and trigger settings and three
// flow-control mixes. Every status transfer is checked against a model.
// ----------------------------------------------------------------------------
module tb_uart_rx_trigger_gated_fifo_top;
	import urtg_pkg::*;
	import urtg_status_sb_pkg::*;

	// Transfers spent on random segments; the overflow run adds the rest.
	localparam int RANDOM_ITEMS   = 240;
	// Cycles without any transfer before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [1:0]  s_tuser = KIND_TICK;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = REG_HALF_BIT_TICKS;
	logic [15:0] cfg_data = '0;

	// Percent of cycles in which the sender holds back or the sink stalls.
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	// Bit timing currently programmed, used to lay out the frames.
	logic [15:0] cur_half = HALF_BIT_TICKS_RESET;
	logic [15:0] cur_bit = BIT_TICKS_RESET;
	int unsigned items_sent = 0;
	int unsigned settings_used = 0;
	int unsigned idle_cycles = 0;
	logic        progress;

	uart_status_scoreboard status_sb = new();

	uart_rx_trigger_gated_fifo_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// The sink decides afresh on every falling edge whether to take a status word.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// All handshakes are observed at the rising edge, before the block's own
	// registers move. Register writes and slave transfers update the model,
	// master transfers are checked. Any transfer resets the watchdog.
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles = 0;
		end else begin
			progress = 1'b0;
			if (cfg_valid && cfg_ready) begin
				status_sb.write_register(cfg_index, cfg_data);
				progress = 1'b1;
			end
			if (s_tvalid && s_tready) begin
				status_sb.note_transfer(s_tuser, s_tdata[0]);
				progress = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				status_sb.check_status(m_tdata);
				progress = 1'b1;
			end
			if (progress)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog expired with %0d status words outstanding.",
					status_sb.pending_status.size());
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Every driving task starts and ends right after a falling edge. Valid is
	// left high between back-to-back transfers and lowered only when idling.
	task automatic send_item(input logic [1:0] kind, input logic rx);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {7'd0, rx};
		do @(posedge clk); while (!(s_tvalid && s_tready));
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_tick(input logic rx);
		send_item(KIND_TICK, rx);
	endtask

	// Holds the sender until every status word has come back. Each transfer
	// yields exactly one status word, so an empty list means the block is idle.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (status_sb.pending_status.size() != 0)
			@(negedge clk);
	endtask

	task automatic put_register(input logic [2:0] index, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		@(negedge clk);
	endtask

	// Rewrites the whole register set while the block is idle.
	task automatic write_config(input logic [15:0] half, input logic [15:0] full,
			input logic filter, input logic open_en, input logic [7:0] open_byte,
			input logic close_en, input logic [7:0] close_byte);
		wait_drained();
		put_register(REG_HALF_BIT_TICKS, half);
		put_register(REG_BIT_TICKS, full);
		put_register(REG_FILTER_ENABLE, {15'd0, filter});
		put_register(REG_START_GATE_ENABLE, {15'd0, open_en});
		put_register(REG_START_GATE_BYTE, {8'd0, open_byte});
		put_register(REG_STOP_GATE_ENABLE, {15'd0, close_en});
		put_register(REG_STOP_GATE_BYTE, {8'd0, close_byte});
		cfg_valid <= 1'b0;
		cur_half = half;
		cur_bit = full;
		settings_used++;
	endtask

	// One 8N1 frame: a high tick so that an edge follows, the falling edge,
	// then start, eight data bits LSB first and the stop bit. Only the last
	// tick of each bit period is sampled, so the earlier ticks sometimes carry
	// the wrong level to show that edges inside a frame are ignored. Pops may
	// fall between any two ticks since they do not advance the line.
	task automatic send_frame(input logic [7:0] value, input logic stop_level,
			input int unsigned pop_pct);
		logic [9:0]  levels;
		int unsigned half_len;
		int unsigned bit_len;
		int unsigned len;
		levels = {stop_level, value, 1'b0};
		half_len = (cur_half == 16'd0) ? 1 : cur_half;
		bit_len = (cur_bit == 16'd0) ? 1 : cur_bit;
		send_tick(1'b1);
		send_tick(1'b0);
		for (int p = 0; p < 10; p++) begin
			len = (p == 0) ? half_len : bit_len;
			for (int t = 1; t <= len; t++) begin
				if ($urandom_range(99) < pop_pct)
					send_item(KIND_POP, 1'($urandom_range(1)));
				if (t < len && $urandom_range(7) == 0)
					send_tick(~levels[p]);
				else
					send_tick(levels[p]);
			end
		end
	endtask

	// A random setting followed by a burst of frames. Data bytes lean toward
	// the trigger bytes so that the gate opens and closes often; a few frames
	// end with a low stop bit and some stray transfers land between frames.
	task automatic run_segment();
		logic [15:0] half;
		logic [15:0] full;
		logic [7:0]  open_byte;
		logic [7:0]  close_byte;
		logic [7:0]  value;
		int unsigned pop_pct;
		half = ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
		full = ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
		open_byte = 8'($urandom_range(255));
		close_byte = ($urandom_range(5) == 0) ? open_byte : 8'($urandom_range(255));
		write_config(half, full, ($urandom_range(3) != 0), 1'($urandom_range(1)),
			open_byte, 1'($urandom_range(1)), close_byte);
		// An enabled stop gate, once closed, needs a restart; send one at times.
		if ($urandom_range(1))
			send_item(KIND_RESTART, 1'($urandom_range(1)));
		pop_pct = $urandom_range(5, 50);
		repeat ($urandom_range(2, 4)) begin
			case ($urandom_range(3))
				0: value = open_byte;
				1: value = close_byte;
				default: value = 8'($urandom_range(255));
			endcase
			send_frame(value, ($urandom_range(9) != 0), pop_pct);
			if ($urandom_range(7) == 0)
				send_item(2'($urandom_range(3)), 1'($urandom_range(1)));
			repeat ($urandom_range(2))
				send_item(KIND_POP, 1'($urandom_range(1)));
		end
	endtask

	// Fills the FIFO one byte past its depth with the gate off, so the last
	// byte is dropped, then pops a few bytes from the full FIFO.
	task automatic overflow_fifo();
		write_config(16'd1, 16'd1, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00);
		send_item(KIND_RESTART, 1'b0);
		repeat (FIFO_SLOTS + 1)
			send_frame(8'($urandom_range(255)), 1'b1, 0);
		repeat (8)
			send_item(KIND_POP, 1'($urandom_range(1)));
	endtask

	initial begin
		int unsigned random_start;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Status-only transfers straight after reset: the unused kind, a pop
		// of the empty FIFO and a restart, each with the line bit set.
		send_item(KIND_UNUSED, 1'b1);
		send_item(KIND_POP, 1'b1);
		send_item(KIND_RESTART, 1'b1);

		// Slowest timing: open a frame, bounce the line inside it, then
		// abandon it with a restart.
		write_config(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		send_item(KIND_RESTART, 1'b0);

		// Zero counts run at one tick per bit. The all-ones byte is both the
		// opening and the closing trigger, so it is queued and shuts the gate.
		write_config(16'd0, 16'd0, 1'b1, 1'b1, 8'hFF, 1'b1, 8'hFF);
		send_frame(8'hFF, 1'b1, 0);
		send_item(KIND_POP, 1'b0);
		send_item(KIND_POP, 1'b1);

		// Random part in three flow-control mixes: a slow sink, a slow
		// sender, then full rate on both sides. Each mix runs at least once.
		random_start = items_sent;
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle_pct = 7;
					recv_stall_pct = 64;
				end
				1: begin
					send_idle_pct = 64;
					recv_stall_pct = 7;
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			do
				run_segment();
			while (items_sent - random_start < (mode + 1) * RANDOM_ITEMS / 3);
		end
		overflow_fifo();

		// Let the last status words arrive, then let the clock run on so that a
		// stray extra word would still be caught.
		wait_drained();
		repeat (4) @(negedge clk);
		$display("Sent %0d transfers under %0d register settings and three %s",
			items_sent, settings_used, "flow-control mixes.");
		$display("Saw %0d good frames, %0d framing errors, %0d bytes popped, %s",
			status_sb.good_frames, status_sb.bad_frames, status_sb.pops_hit,
			$sformatf("%0d dropped, %0d gate closures.",
				status_sb.drops, status_sb.gate_closures));
		if (status_sb.mismatches == 0 && status_sb.pending_status.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
